@@ rtl/core/swfd_pkg.sv @@
// Package for the sync word frame deframer.
// Holds shared constants, codes, types and the sync pattern function; no dependencies.
package swfd_pkg;

    localparam int unsigned SYNC_BYTES_DEF = 8;
    localparam int unsigned CFG_IDX_W      = 1;
    localparam int unsigned CFG_DATA_W     = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SYNC_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_HIGH = 1'b1;

    localparam logic [31:0] SYNC_LOW_RST  = 32'h1234_5678;
    localparam logic [31:0] SYNC_HIGH_RST = 32'h8765_4321;

    localparam logic [1:0] KIND_TEXT = 2'd0;
    localparam logic [1:0] KIND_NAME = 2'd1;
    localparam logic [1:0] KIND_DATA = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_SEP  = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic [1:0] ST_SHORT   = 2'd3;

    localparam logic [31:0] TYPE_TEXT   = 32'd0;
    localparam logic [31:0] TYPE_BINARY = 32'd1;
    localparam logic [7:0]  SEP_CHAR    = 8'h7C;
    localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_HEADER,
        PH_BODY
    } t_phase;

    typedef struct packed {
        logic       evict;
        logic [7:0] old_byte;
        logic [7:0] next_head;
        logic       sync;
    } t_win_info;

    typedef struct packed {
        logic [1:0]  byte_kind;
        logic [7:0]  out_byte;
        logic        frame_end;
        logic [31:0] frame_type;
        logic [31:0] declared_length;
        logic [31:0] body_bytes;
        logic [1:0]  frame_status;
    } t_result;

    function automatic logic [7:0] pattern_byte(input logic [31:0] low,
                                                input logic [31:0] high,
                                                input int unsigned idx);
        logic [7:0] res;
        if (idx < 4) begin
            res = low[8*idx +: 8];
        end else if (idx < 8) begin
            res = high[8*(idx-4) +: 8];
        end else begin
            res = 8'h00;
        end
        return res;
    endfunction

endpackage

@@ rtl/core/swfd_byte_if.sv @@
// Input channel of the deframer: one raw stream byte per transfer.
// Depends on nothing.
interface swfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

@@ rtl/core/swfd_result_if.sv @@
// Result channel of the deframer: payload byte and frame report per transfer.
// Depends on nothing.
interface swfd_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  byte_kind;
    logic [7:0]  out_byte;
    logic        frame_end;
    logic [31:0] frame_type;
    logic [31:0] declared_length;
    logic [31:0] body_bytes;
    logic [1:0]  frame_status;

    modport source (output valid, output byte_kind, output out_byte, output frame_end,
                    output frame_type, output declared_length, output body_bytes,
                    output frame_status, input ready);
    modport sink   (input valid, input byte_kind, input out_byte, input frame_end,
                    input frame_type, input declared_length, input body_bytes,
                    input frame_status, output ready);
endinterface

@@ rtl/core/swfd_window.sv @@
// Delay window, sync pattern registers and parallel pattern compare.
// Depends on swfd_pkg.
module swfd_window #(
    parameter int unsigned SYNC_BYTES = swfd_pkg::SYNC_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [swfd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [swfd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_accept,
    input  logic [7:0]                       i_byte,
    output swfd_pkg::t_win_info              o_info
);

    localparam int unsigned FILL_W = $clog2(SYNC_BYTES + 1);

    logic [31:0]       r_sync_low;
    logic [31:0]       r_sync_high;
    logic [7:0]        r_win [SYNC_BYTES];
    logic [7:0]        n_win [SYNC_BYTES];
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic              evict;
    logic              full_next;
    logic              match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_low  <= swfd_pkg::SYNC_LOW_RST;
            r_sync_high <= swfd_pkg::SYNC_HIGH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                swfd_pkg::REG_SYNC_LOW:  r_sync_low  <= i_cfg_data;
                swfd_pkg::REG_SYNC_HIGH: r_sync_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign evict     = (r_fill == FILL_W'(SYNC_BYTES));
    assign full_next = evict || (r_fill == FILL_W'(SYNC_BYTES - 1));

    always_comb begin
        for (int i = 0; i < SYNC_BYTES; i++) begin
            if (evict) begin
                n_win[i] = (i == SYNC_BYTES - 1) ? i_byte : r_win[(i + 1) % SYNC_BYTES];
            end else if (r_fill == FILL_W'(i)) begin
                n_win[i] = i_byte;
            end else begin
                n_win[i] = r_win[i];
            end
        end
    end

    always_comb begin
        match = full_next;
        for (int i = 0; i < SYNC_BYTES; i++) begin
            if (n_win[i] != swfd_pkg::pattern_byte(r_sync_low, r_sync_high, i)) begin
                match = 1'b0;
            end
        end
    end

    always_comb begin
        if (match) begin
            n_fill = '0;
        end else if (evict) begin
            n_fill = r_fill;
        end else begin
            n_fill = r_fill + FILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_accept) begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_win <= n_win;
        end
    end

    assign o_info.evict     = evict;
    assign o_info.old_byte  = r_win[0];
    assign o_info.next_head = n_win[0];
    assign o_info.sync      = match;

    a_sync_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && match) |=> (r_fill == '0))
        else $error("window not emptied after a sync match");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= FILL_W'(SYNC_BYTES)))
        else $error("window fill beyond window size");

endmodule

@@ rtl/core/swfd_frame.sv @@
// Frame tracker: header collection, body classification and frame reports.
// Depends on swfd_pkg.
module swfd_frame (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  swfd_pkg::t_win_info  i_info,
    output logic                 o_res_valid,
    output swfd_pkg::t_result    o_res
);

    swfd_pkg::t_phase r_phase;
    swfd_pkg::t_phase n_phase;
    logic [2:0]       r_hdr_cnt;
    logic [2:0]       n_hdr_cnt;
    logic [31:0]      r_type;
    logic [31:0]      n_type;
    logic [31:0]      r_len;
    logic [31:0]      n_len;
    logic [31:0]      r_body;
    logic [31:0]      n_body;
    logic             r_sep_seen;
    logic             n_sep_seen;
    logic             r_skip;
    logic             n_skip;

    logic             hdr_done;
    logic             fend;
    logic [1:0]       kind;
    logic [1:0]       status;
    logic [2:0]       m_hdr_cnt;
    logic [31:0]      m_type;
    logic [31:0]      m_len;
    logic [31:0]      m_body;
    logic             m_sep_seen;
    logic             m_skip;

    assign hdr_done = (r_phase == swfd_pkg::PH_HEADER) && i_info.evict && (r_hdr_cnt == 3'd7);
    assign fend     = i_info.sync && (r_phase != swfd_pkg::PH_HUNT);

    always_comb begin
        n_phase = r_phase;
        if (hdr_done) begin
            n_phase = swfd_pkg::PH_BODY;
        end
        if (i_info.sync) begin
            n_phase = swfd_pkg::PH_HEADER;
        end
    end

    always_comb begin
        m_hdr_cnt  = r_hdr_cnt;
        m_type     = r_type;
        m_len      = r_len;
        m_body     = r_body;
        m_sep_seen = r_sep_seen;
        m_skip     = r_skip;
        kind       = swfd_pkg::KIND_NONE;
        if (i_info.evict && (r_phase == swfd_pkg::PH_HEADER)) begin
            for (int k = 0; k < 4; k++) begin
                if (r_hdr_cnt[1:0] == 2'(k)) begin
                    if (!r_hdr_cnt[2]) begin
                        m_type[8*k +: 8] = i_info.old_byte;
                    end else begin
                        m_len[8*k +: 8] = i_info.old_byte;
                    end
                end
            end
            m_hdr_cnt = r_hdr_cnt + 3'd1;
        end else if (i_info.evict && (r_phase == swfd_pkg::PH_BODY)) begin
            if (r_body != swfd_pkg::COUNT_MAX) begin
                m_body = r_body + 32'd1;
            end
            if (r_skip) begin
                m_skip = 1'b0;
            end else if (r_type == swfd_pkg::TYPE_TEXT) begin
                kind = swfd_pkg::KIND_TEXT;
            end else if (r_type == swfd_pkg::TYPE_BINARY) begin
                if (r_sep_seen) begin
                    kind = swfd_pkg::KIND_DATA;
                end else if ((i_info.old_byte == swfd_pkg::SEP_CHAR) && !i_info.sync &&
                             (i_info.next_head == swfd_pkg::SEP_CHAR)) begin
                    m_sep_seen = 1'b1;
                    m_skip     = 1'b1;
                end else begin
                    kind = swfd_pkg::KIND_NAME;
                end
            end
        end
    end

    always_comb begin
        if ((r_phase == swfd_pkg::PH_HEADER) && !hdr_done) begin
            status = swfd_pkg::ST_SHORT;
        end else if (m_type > swfd_pkg::TYPE_BINARY) begin
            status = swfd_pkg::ST_UNKNOWN;
        end else if ((m_type == swfd_pkg::TYPE_BINARY) && !m_sep_seen) begin
            status = swfd_pkg::ST_NO_SEP;
        end else begin
            status = swfd_pkg::ST_OK;
        end
    end

    always_comb begin
        if (i_info.sync) begin
            n_hdr_cnt  = '0;
            n_type     = '0;
            n_len      = '0;
            n_body     = '0;
            n_sep_seen = 1'b0;
            n_skip     = 1'b0;
        end else begin
            n_hdr_cnt  = m_hdr_cnt;
            n_type     = m_type;
            n_len      = m_len;
            n_body     = m_body;
            n_sep_seen = m_sep_seen;
            n_skip     = m_skip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= swfd_pkg::PH_HUNT;
            r_hdr_cnt  <= '0;
            r_type     <= '0;
            r_len      <= '0;
            r_body     <= '0;
            r_sep_seen <= 1'b0;
            r_skip     <= 1'b0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_hdr_cnt  <= n_hdr_cnt;
            r_type     <= n_type;
            r_len      <= n_len;
            r_body     <= n_body;
            r_sep_seen <= n_sep_seen;
            r_skip     <= n_skip;
        end
    end

    assign o_res_valid           = i_accept && ((kind != swfd_pkg::KIND_NONE) || fend);
    assign o_res.byte_kind       = kind;
    assign o_res.out_byte        = (kind != swfd_pkg::KIND_NONE) ? i_info.old_byte : 8'h00;
    assign o_res.frame_end       = fend;
    assign o_res.frame_type      = fend ? m_type : 32'd0;
    assign o_res.declared_length = fend ? m_len : 32'd0;
    assign o_res.body_bytes      = fend ? m_body : 32'd0;
    assign o_res.frame_status    = fend ? status : swfd_pkg::ST_OK;

    a_skip_after_sep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip |-> (r_sep_seen && (r_phase == swfd_pkg::PH_BODY)))
        else $error("separator skip pending without a separator in a body");

    a_hunt_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == swfd_pkg::PH_HUNT) |-> ((r_body == '0) && !r_sep_seen && (r_hdr_cnt == '0)))
        else $error("frame state dirty while hunting for the first sync");

endmodule

@@ rtl/core/swfd_out_buf.sv @@
// Two-entry output register with skid stage for the result channel.
// Depends on swfd_pkg and swfd_result_if.
module swfd_out_buf (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push_valid,
    input  swfd_pkg::t_result     i_push_data,
    output logic                  o_push_ready,
    swfd_result_if.source         o_result
);

    logic              r_main_valid;
    logic              r_skid_valid;
    swfd_pkg::t_result r_main;
    swfd_pkg::t_result r_skid;
    logic              push;
    logic              pop;

    assign o_push_ready = !r_skid_valid;
    assign push         = i_push_valid && !r_skid_valid;
    assign pop          = r_main_valid && o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_main_valid || pop) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= push;
            end
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_main_valid || pop) begin
            r_main <= r_skid_valid ? r_skid : i_push_data;
        end else if (push) begin
            r_skid <= i_push_data;
        end
    end

    assign o_result.valid           = r_main_valid;
    assign o_result.byte_kind       = r_main.byte_kind;
    assign o_result.out_byte        = r_main.out_byte;
    assign o_result.frame_end       = r_main.frame_end;
    assign o_result.frame_type      = r_main.frame_type;
    assign o_result.declared_length = r_main.declared_length;
    assign o_result.body_bytes      = r_main.body_bytes;
    assign o_result.frame_status    = r_main.frame_status;

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry held while the output register is empty");

endmodule

@@ rtl/core/sync_word_frame_deframer.sv @@
// Top level of the sync word frame deframer.
// Depends on swfd_pkg, swfd_byte_if, swfd_result_if, swfd_window, swfd_frame and swfd_out_buf.
//
// Raw stream bytes arrive on i_byte, one per transfer. Each byte passes through a
// delay window of SYNC_BYTES bytes that is compared in parallel against the sync
// pattern held in two configuration registers, written through i_cfg_we,
// i_cfg_index and i_cfg_data; the user must write them only while the block is
// idle, which the block does not enforce. A body byte leaving the window is
// classified as text, filename or binary data and sent on o_result, apart from the
// separator pair and unknown types; a sync match after the first sends a frame
// report with type, declared length, body count and status. Bytes ahead of the
// first sync word are dropped. Payload appears only SYNC_BYTES input transfers
// after its own byte entered. One byte is taken in every cycle while i_byte.ready
// is high; a result is registered in the output buffer before it reaches o_result.
// Inputs that cause no result are absorbed silently. When the receiver stalls, a
// two-entry output buffer holds results and i_byte.ready falls only once both
// entries are full. Reset restores the default sync pattern, empties the window and
// the output buffer, and starts hunting for the first sync word.
module sync_word_frame_deframer #(
    parameter int unsigned SYNC_BYTES = swfd_pkg::SYNC_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [swfd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [swfd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    swfd_byte_if.sink                        i_byte,
    swfd_result_if.source                    o_result
);

    logic                accept;
    logic                push_ready;
    logic                res_valid;
    swfd_pkg::t_win_info win_info;
    swfd_pkg::t_result   res;

    assign i_byte.ready = push_ready;
    assign accept       = i_byte.valid && push_ready;

    swfd_window #(
        .SYNC_BYTES (SYNC_BYTES)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_byte      (i_byte.data_byte),
        .o_info      (win_info)
    );

    swfd_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_info      (win_info),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    swfd_out_buf u_out_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (res_valid),
        .i_push_data  (res),
        .o_push_ready (push_ready),
        .o_result     (o_result)
    );

endmodule
